// ===== rtl/object_header_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Object header parser assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef OBJECT_HEADER_PARSER_TOP_MACROS_SVH
`define OBJECT_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication.
`define OHP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("object header parser check failed");

// Next-cycle implication.
`define OHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("object header parser check failed");

`endif

// ===== rtl/ohp_pkg.sv =====
// ----------------------------------------------------------------------------
// Object header parser package
// Phase codes, object type codes, header constants and control state type.
// ----------------------------------------------------------------------------
package ohp_pkg;

  localparam int DEFAULT_LENGTH_BITS = 32;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_SIZE    = 2'd1,
    PH_CONTENT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    OBJ_BLOB   = 2'd0,
    OBJ_TREE   = 2'd1,
    OBJ_COMMIT = 2'd2
  } obj_type_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int NUM_TYPES = 3;

  // Type names, padded with NUL up to eight positions.
  localparam logic [7:0] TYPE_NAME [NUM_TYPES][8] = '{
    '{8'h62, 8'h6c, 8'h6f, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h72, 8'h65, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h6f, 8'h6d, 8'h6d, 8'h69, 8'h74, 8'h00, 8'h00}
  };
  localparam logic [2:0] TYPE_LEN [NUM_TYPES] = '{3'd4, 3'd4, 3'd6};

  typedef struct packed {
    phase_t          phase;
    logic [2:0]      type_pos;
    logic [2:0]      type_cand;
    obj_type_t       matched;
    logic [1:0]      digit_cnt;
    logic            lead_zero;
    logic            err;
  } ohp_ctrl_t;

  localparam ohp_ctrl_t CTRL_RESET = '{
    phase:     PH_TYPE,
    type_pos:  3'd0,
    type_cand: 3'b111,
    matched:   OBJ_BLOB,
    digit_cnt: 2'd0,
    lead_zero: 1'b0,
    err:       1'b0
  };

endpackage

// ===== rtl/object_header_parser_top.sv =====
// A byte accepted into the input register shows its result from the result register.
// One byte per cycle unless res_ready stalls; the parse state updates once per byte.
// The input register holds one byte while the result register waits on res_ready.
// Reset (rst, synchronous): drops both stages and returns the parser to the type field.
// ----------------------------------------------------------------------------
// Object header parser top level
// Checks a "type size NUL" header, passes content through and reports status.
// ----------------------------------------------------------------------------
module object_header_parser_top #(
  parameter int LENGTH_BITS = ohp_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        raw_valid,
  output logic        raw_ready,
  input  logic [7:0]  raw_byte,
  input  logic        last_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  content_byte,
  output logic        content_valid,
  output logic        done_res,
  output logic        status,
  output logic [1:0]  object_type,
  output logic [31:0] header_size
);
  import ohp_pkg::*;

  ohp_ctrl_t              ctrl;
  ohp_ctrl_t              ctrl_next;
  logic [LENGTH_BITS-1:0] acc;
  logic [LENGTH_BITS-1:0] acc_next;
  logic [LENGTH_BITS-1:0] cnt;
  logic [LENGTH_BITS-1:0] cnt_next;

  logic                   hold_valid;
  logic [7:0]             hold_byte;
  logic                   hold_last;
  logic                   advance;

  logic [7:0]             step_byte;
  logic                   step_valid;
  logic                   step_done;
  logic                   step_status;
  logic [1:0]             step_type;
  logic [31:0]            step_size;

  assign advance   = hold_valid && (!res_valid || res_ready);
  assign raw_ready = !hold_valid || advance;

  ohp_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .ctrl          (ctrl),
    .acc           (acc),
    .cnt           (cnt),
    .raw_byte      (hold_byte),
    .last_byte     (hold_last),
    .ctrl_next     (ctrl_next),
    .acc_next      (acc_next),
    .cnt_next      (cnt_next),
    .content_byte  (step_byte),
    .content_valid (step_valid),
    .done_res      (step_done),
    .status        (step_status),
    .object_type   (step_type),
    .header_size   (step_size)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (raw_ready) begin
      hold_valid <= raw_valid;
    end
    if (raw_valid && raw_ready) begin
      hold_byte <= raw_byte;
      hold_last <= last_byte;
    end
  end

  // parse state, advanced once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= CTRL_RESET;
      acc  <= '0;
      cnt  <= '0;
    end else if (advance) begin
      ctrl <= ctrl_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      content_byte  <= step_byte;
      content_valid <= step_valid;
      done_res      <= step_done;
      status        <= step_status;
      object_type   <= step_type;
      header_size   <= step_size;
    end
  end

endmodule

// ===== rtl/ohp_step.sv =====
// ----------------------------------------------------------------------------
// Object header parser step
// Next-state and result logic for one byte against the current parse state.
// ----------------------------------------------------------------------------
module ohp_step #(
  parameter int LENGTH_BITS = ohp_pkg::DEFAULT_LENGTH_BITS
) (
  input  ohp_pkg::ohp_ctrl_t     ctrl,
  input  logic [LENGTH_BITS-1:0] acc,
  input  logic [LENGTH_BITS-1:0] cnt,
  input  logic [7:0]             raw_byte,
  input  logic                   last_byte,
  output ohp_pkg::ohp_ctrl_t     ctrl_next,
  output logic [LENGTH_BITS-1:0] acc_next,
  output logic [LENGTH_BITS-1:0] cnt_next,
  output logic [7:0]             content_byte,
  output logic                   content_valid,
  output logic                   done_res,
  output logic                   status,
  output logic [1:0]             object_type,
  output logic [31:0]            header_size
);
  import ohp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  ohp_ctrl_t               ctrl_upd;
  logic [LENGTH_BITS-1:0]  acc_upd;
  logic [LENGTH_BITS-1:0]  cnt_upd;
  logic [7:0]              digit_raw;
  logic [3:0]              digit;
  logic                    is_digit;
  logic [LENGTH_BITS+3:0]  acc_ext;
  logic [LENGTH_BITS+3:0]  scaled;
  logic                    size_ovf;
  logic [LENGTH_BITS+31:0] size_ext;

  // acc * 10 + digit, with the top four bits flagging overflow
  always_comb begin
    digit_raw = raw_byte - CH_ZERO;
    digit     = digit_raw[3:0];
    is_digit  = (raw_byte >= CH_ZERO) && (raw_byte <= CH_NINE);
    acc_ext   = {4'b0000, acc};
    scaled    = (acc_ext << 3) + (acc_ext << 1) + {{LENGTH_BITS{1'b0}}, digit};
    size_ovf  = |scaled[LENGTH_BITS+3:LENGTH_BITS];
  end

  // Next state for this byte
  always_comb begin
    ctrl_upd = ctrl;
    acc_upd  = acc;
    cnt_upd  = cnt;
    unique case (ctrl.phase)
      PH_TYPE: begin
        if (raw_byte == CH_SPACE) begin
          ctrl_upd.err = 1'b1;
          for (int k = 0; k < NUM_TYPES; k++) begin
            if (ctrl.type_cand[k] && (TYPE_LEN[k] == ctrl.type_pos)) begin
              ctrl_upd.matched = obj_type_t'(2'(k));
              ctrl_upd.err     = ctrl.err;
            end
          end
          ctrl_upd.phase = PH_SIZE;
        end else if (raw_byte == CH_NUL) begin
          ctrl_upd.err   = 1'b1;
          ctrl_upd.phase = PH_CONTENT;
        end else begin
          for (int k = 0; k < NUM_TYPES; k++) begin
            if ((ctrl.type_pos >= TYPE_LEN[k]) || (TYPE_NAME[k][ctrl.type_pos] != raw_byte)) begin
              ctrl_upd.type_cand[k] = 1'b0;
            end
          end
          if (ctrl.type_pos != 3'd7) begin
            ctrl_upd.type_pos = ctrl.type_pos + 3'd1;
          end
        end
      end
      PH_SIZE: begin
        if (raw_byte == CH_NUL) begin
          if ((ctrl.digit_cnt == 2'd0) || (ctrl.lead_zero && (ctrl.digit_cnt == 2'd2))) begin
            ctrl_upd.err = 1'b1;
          end
          ctrl_upd.phase = PH_CONTENT;
        end else if (is_digit) begin
          if ((ctrl.digit_cnt == 2'd0) && (digit == 4'd0)) begin
            ctrl_upd.lead_zero = 1'b1;
          end
          if (ctrl.digit_cnt != 2'd2) begin
            ctrl_upd.digit_cnt = ctrl.digit_cnt + 2'd1;
          end
          if (size_ovf) begin
            ctrl_upd.err = 1'b1;
            acc_upd      = LEN_MAX;
          end else begin
            acc_upd = scaled[LENGTH_BITS-1:0];
          end
        end else begin
          ctrl_upd.err = 1'b1;
        end
      end
      default: begin
        // content, and the unused phase code
        if (cnt == LEN_MAX) begin
          ctrl_upd.err = 1'b1;
        end else begin
          cnt_upd = cnt + 1'b1;
        end
      end
    endcase
  end

  // Results, and return to the start state after the last byte
  always_comb begin
    size_ext      = {32'd0, acc_upd};
    content_valid = (ctrl.phase != PH_TYPE) && (ctrl.phase != PH_SIZE);
    content_byte  = content_valid ? raw_byte : 8'd0;
    done_res      = last_byte;
    status        = 1'b0;
    object_type   = 2'd0;
    header_size   = 32'd0;
    ctrl_next     = ctrl_upd;
    acc_next      = acc_upd;
    cnt_next      = cnt_upd;
    if (last_byte) begin
      status = ctrl_upd.err || (ctrl_upd.phase == PH_TYPE) || (ctrl_upd.phase == PH_SIZE) ||
               (cnt_upd != acc_upd);
      object_type   = ctrl_upd.matched;
      header_size   = size_ext[31:0];
      ctrl_next     = CTRL_RESET;
      acc_next      = '0;
      cnt_next      = '0;
    end
  end

endmodule

// ===== rtl/ohp_checker.sv =====
// ----------------------------------------------------------------------------
// Object header parser port checker
// Watches the top-level ports for result stability and field consistency.
// ----------------------------------------------------------------------------
`include "object_header_parser_top_macros.svh"

module ohp_checker (
  input logic        clk,
  input logic        rst,
  input logic        raw_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  content_byte,
  input logic        content_valid,
  input logic        done_res,
  input logic        status,
  input logic [1:0]  object_type,
  input logic [31:0] header_size
);

  // a stalled result holds
  `OHP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
                   res_valid && $stable(content_byte) && $stable(done_res) && $stable(header_size))

  // status fields are zero except on the last byte
  `OHP_ASSERT_NOW(a_idle_status, res_valid && !done_res, !status && (object_type == 2'd0) && (header_size == 32'd0))

  // header bytes pass no data
  `OHP_ASSERT_NOW(a_hdr_zero, res_valid && !content_valid, content_byte == 8'd0)

  // a well-formed object names a known type
  `OHP_ASSERT_NOW(a_ok_type, res_valid && done_res && !status, object_type != 2'd3)

  // with no result waiting the input is always open
  `OHP_ASSERT_NOW(a_ready_free, !res_valid, raw_ready)

endmodule

bind object_header_parser_top ohp_checker u_ohp_checker (
  .clk           (clk),
  .rst           (rst),
  .raw_ready     (raw_ready),
  .res_valid     (res_valid),
  .res_ready     (res_ready),
  .content_byte  (content_byte),
  .content_valid (content_valid),
  .done_res      (done_res),
  .status        (status),
  .object_type   (object_type),
  .header_size   (header_size)
);

// ===== tb/sv/ohp_parse_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Object header parser scoreboard
// Tracks the header parse byte by byte and checks every result in order.
// ----------------------------------------------------------------------------
package ohp_parse_scoreboard_pkg;

  import ohp_pkg::*;

  typedef struct packed {
    logic [7:0]  content_byte;
    logic        content_valid;
    logic        done_res;
    logic        status;
    logic [1:0]  object_type;
    logic [31:0] header_size;
  } parse_result_t;

  localparam logic [63:0] SIZE_LIMIT = 64'h0000_0000_FFFF_FFFF;

  class parse_scoreboard;

    phase_t      stage;
    logic [2:0]  type_idx;
    logic [2:0]  cand;
    obj_type_t   hit_type;
    logic [63:0] size_acc;
    logic [1:0]  digit_cnt;
    logic        lead_zero;
    logic [63:0] content_cnt;
    logic        corrupt;

    parse_result_t pending_reports[$];
    int unsigned   fail_count;

    function new();
      clear_parse();
      fail_count = 0;
    endfunction

    function void clear_parse();
      stage       = PH_TYPE;
      type_idx    = 3'd0;
      cand        = 3'b111;
      hit_type    = OBJ_BLOB;
      size_acc    = '0;
      digit_cnt   = 2'd0;
      lead_zero   = 1'b0;
      content_cnt = '0;
      corrupt     = 1'b0;
    endfunction

    // Advance the parse by one accepted request and queue its result.
    function void note_byte(logic [7:0] b, logic last);
      parse_result_t r;
      logic          found;
      logic [63:0]   d;
      r = '0;
      case (stage)
        PH_TYPE: begin
          if (b == CH_SPACE) begin
            found = 1'b0;
            for (int k = 0; k < NUM_TYPES; k++) begin
              if (cand[k] && TYPE_LEN[k] == type_idx) begin
                hit_type = obj_type_t'(2'(k));
                found = 1'b1;
              end
            end
            if (!found) corrupt = 1'b1;
            stage = PH_SIZE;
          end else if (b == CH_NUL) begin
            corrupt = 1'b1;
            stage = PH_CONTENT;
          end else begin
            for (int k = 0; k < NUM_TYPES; k++) begin
              if (type_idx >= TYPE_LEN[k] || TYPE_NAME[k][type_idx] != b) cand[k] = 1'b0;
            end
            if (type_idx < 3'd7) type_idx = type_idx + 3'd1;
          end
        end
        PH_SIZE: begin
          if (b == CH_NUL) begin
            if (digit_cnt == 2'd0 || (lead_zero && digit_cnt >= 2'd2)) corrupt = 1'b1;
            stage = PH_CONTENT;
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            d = 64'(b - CH_ZERO);
            if (digit_cnt == 2'd0 && d == 0) lead_zero = 1'b1;
            if (digit_cnt < 2'd2) digit_cnt = digit_cnt + 2'd1;
            // Saturate the accumulator once the value no longer fits.
            if (size_acc > (SIZE_LIMIT - d) / 10) begin
              corrupt = 1'b1;
              size_acc = SIZE_LIMIT;
            end else begin
              size_acc = size_acc * 10 + d;
            end
          end else begin
            corrupt = 1'b1;
          end
        end
        default: begin
          r.content_byte  = b;
          r.content_valid = 1'b1;
          if (content_cnt >= SIZE_LIMIT) corrupt = 1'b1;
          else content_cnt = content_cnt + 1;
        end
      endcase
      if (last) begin
        r.done_res      = 1'b1;
        r.status        = corrupt || stage != PH_CONTENT || content_cnt != size_acc;
        r.object_type   = hit_type;
        r.header_size   = size_acc[31:0];
        clear_parse();
      end
      pending_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
        fail_count++;
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t e;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      e = pending_reports.pop_front();
      compare_field("content_byte", 32'(e.content_byte), 32'(got.content_byte));
      compare_field("content_valid", 32'(e.content_valid), 32'(got.content_valid));
      compare_field("done_res", 32'(e.done_res), 32'(got.done_res));
      compare_field("status", 32'(e.status), 32'(got.status));
      compare_field("object_type", 32'(e.object_type), 32'(got.object_type));
      compare_field("header_size", e.header_size, got.header_size);
    endfunction

    function int unsigned pending();
      return pending_reports.size();
    endfunction

  endclass

endpackage

// ===== tb/sv/tb_object_header_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Object header parser testbench
// Streams directed and random objects, well formed and damaged, through the
// parser under random idling on both channels and checks every result.
// ----------------------------------------------------------------------------
module tb_object_header_parser_top;

  import ohp_pkg::*;
  import ohp_parse_scoreboard_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        raw_valid;
  logic        raw_ready;
  logic [7:0]  raw_byte;
  logic        last_byte;
  logic        res_valid;
  logic        res_ready;
  logic [7:0]  content_byte;
  logic        content_valid;
  logic        done_res;
  logic        status;
  logic [1:0]  object_type;
  logic [31:0] header_size;

  parse_scoreboard sb = new();

  logic [7:0]  object_bytes[$];
  int unsigned bytes_sent   = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_request = 1'b0;

  object_header_parser_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .raw_valid     (raw_valid),
    .raw_ready     (raw_ready),
    .raw_byte      (raw_byte),
    .last_byte     (last_byte),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .content_byte  (content_byte),
    .content_valid (content_valid),
    .done_res      (done_res),
    .status        (status),
    .object_type   (object_type),
    .header_size   (header_size)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: check results and drive res_ready, with an occasional long hold.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        sb.check_result('{content_byte, content_valid, done_res, status,
                          object_type, header_size});
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    object_bytes.push_back(b);
  endfunction

  function automatic void add_text(string t);
    for (int i = 0; i < t.len(); i++) object_bytes.push_back(t[i]);
  endfunction

  function automatic void add_header(string tname, string digits);
    add_text(tname);
    add_byte(CH_SPACE);
    add_text(digits);
    add_byte(CH_NUL);
  endfunction

  task automatic send_byte(logic [7:0] b, logic l);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      raw_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    raw_valid <= 1'b1;
    raw_byte  <= b;
    last_byte <= l;
    do @(posedge clk); while (!raw_ready);
    sb.note_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_object();
    for (int i = 0; i < object_bytes.size(); i++) begin
      send_byte(object_bytes[i], i == object_bytes.size() - 1);
    end
    object_bytes.delete();
  endtask

  // Hold the sender until every expected result is back.
  task automatic drain();
    raw_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void build_random_object();
    int unsigned pick, kind, len, clen, idx, cut, n;
    string       tname, digits;
    pick = $urandom_range(2);
    tname = (pick == 0) ? "blob" : (pick == 1) ? "tree" : "commit";
    len = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(12);
    digits = $sformatf("%0d", len);
    kind = ($urandom_range(99) < 70) ? 0 : $urandom_range(7, 1);
    case (kind)
      1: begin
        idx = $urandom_range(tname.len() - 1);
        tname[idx] = 8'($urandom_range(255, 1));
      end
      2: digits = {"0", digits};
      3: begin
        case ($urandom_range(3))
          0: digits = "4294967295";
          1: digits = "4294967296";
          2: digits = $sformatf("%0d", {$urandom, $urandom});
          default: digits = $sformatf("%0d", $urandom);
        endcase
      end
      4: digits = $urandom_range(1) ? {"-", digits} : {digits, " "};
      default: ;
    endcase
    add_header(tname, digits);
    clen = len;
    if (kind == 5) clen = ($urandom_range(1) || len == 0) ? len + 1 : len - 1;
    repeat (clen) add_byte(8'($urandom));
    if (kind == 6) begin
      cut = $urandom_range(object_bytes.size() - 1, 1);
      repeat (cut) void'(object_bytes.pop_back());
    end
    if (kind == 7) begin
      object_bytes.delete();
      n = $urandom_range(12, 1);
      repeat (n) begin
        case ($urandom_range(4))
          0: add_byte(CH_NUL);
          1: add_byte(CH_SPACE);
          2: add_byte(8'($urandom_range(CH_NINE, CH_ZERO)));
          3: add_byte(TYPE_NAME[$urandom_range(NUM_TYPES - 1)][$urandom_range(5)]);
          default: add_byte(8'($urandom));
        endcase
      end
    end
  endfunction

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct,
                           int unsigned n_bytes, bit with_hold);
    int unsigned target;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (with_hold) hold_request = 1'b1;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      build_random_object();
      send_object();
    end
    drain();
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    raw_valid <= 1'b0;
    raw_byte  <= 8'h00;
    last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 31;
    snk_idle_pct = 59;
    // Well formed, including empty content and content with NUL and extremes.
    add_header("blob", "0"); send_object();
    add_header("tree", "3"); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h80);
    send_object();
    add_header("commit", "2"); add_text("ab"); send_object();
    // Missing space: content still passes through.
    add_text("blob"); add_byte(CH_NUL); add_text("xy"); send_object();
    // Missing NUL.
    add_text("blob 5"); send_object();
    // Bad types, empty type included.
    add_header("blobs", "1"); add_text("x"); send_object();
    add_header("", "1"); add_text("x"); send_object();
    add_header("com", "0"); send_object();
    // Bad sizes: empty, minus sign, second space, leading zero.
    add_header("tree", ""); send_object();
    add_header("blob", "-1"); add_text("x"); send_object();
    add_header("blob", "1 "); add_text("x"); send_object();
    add_header("blob", "01"); add_text("x"); send_object();
    // Largest size that fits, then one past it.
    add_header("commit", "4294967295"); add_text("z"); send_object();
    add_header("blob", "4294967296"); send_object();
    // Count mismatch and a header cut off after one byte.
    add_header("tree", "2"); add_text("abc"); send_object();
    add_byte(8'hFF); send_object();
    drain();

    run_phase(31, 59, 620, 1'b0);
    run_phase(59, 31, 620, 1'b0);
    run_phase(0, 0, 620, 1'b1);

    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
